/* sv/lbec_pkg.sv */
// Shared types and constants for the LED blink error classifier.
`timescale 1ns / 1ps
package lbec_pkg;

	localparam int LEVEL_W = 10;
	localparam int TIME_W  = 32;
	localparam int MS_W    = 16;
	localparam int BLINK_W = 8;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 16;
	localparam int IN_DW   = 56;
	localparam int OUT_DW  = 8;

	// Register indexes on the configuration port
	localparam logic [CFG_AW-1:0] REG_ON_THRESHOLD = 3'd0;
	localparam logic [CFG_AW-1:0] REG_BOOT_HOLDOFF = 3'd1;
	localparam logic [CFG_AW-1:0] REG_RED_RECENT   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_GREEN_SOLID  = 3'd3;
	localparam logic [CFG_AW-1:0] REG_BLINK_LIMIT  = 3'd4;

	// Register reset values
	localparam logic [LEVEL_W-1:0] RST_ON_THRESHOLD = 10'd450;
	localparam logic [MS_W-1:0]    RST_BOOT_HOLDOFF = 16'd1500;
	localparam logic [MS_W-1:0]    RST_RED_RECENT   = 16'd1000;
	localparam logic [MS_W-1:0]    RST_GREEN_SOLID  = 16'd500;
	localparam logic [BLINK_W-1:0] RST_BLINK_LIMIT  = 8'd2;

	// Colour codes; the last-colour register uses an extra code for "none yet"
	localparam logic [1:0] COLOR_BLACK  = 2'd0;
	localparam logic [1:0] COLOR_RED    = 2'd1;
	localparam logic [1:0] COLOR_GREEN  = 2'd2;
	localparam logic [1:0] COLOR_ORANGE = 2'd3;
	localparam logic [2:0] COLOR_NONE   = 3'd4;

	localparam logic [BLINK_W-1:0] BLINK_MAX = {BLINK_W{1'b1}};

	typedef struct packed {
		logic [LEVEL_W-1:0] on_threshold;
		logic [MS_W-1:0]    boot_holdoff_ms;
		logic [MS_W-1:0]    red_recent_ms;
		logic [MS_W-1:0]    green_solid_ms;
		logic [BLINK_W-1:0] blink_limit;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]  now_ms;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
	} item_t;

	typedef struct packed {
		logic       rainbow_restart;
		logic       color_write;
		logic [1:0] color_code;
		logic       error_flag;
	} result_t;

endpackage

/* sv/lbec_cfg.sv */
// Configuration register file of the LED blink error classifier.
`timescale 1ns / 1ps
module lbec_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lbec_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [lbec_pkg::CFG_DW-1:0]   cfg_wdata,
	output lbec_pkg::cfg_t                cfg
);
	import lbec_pkg::*;

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_threshold    <= RST_ON_THRESHOLD;
			cfg_q.boot_holdoff_ms <= RST_BOOT_HOLDOFF;
			cfg_q.red_recent_ms   <= RST_RED_RECENT;
			cfg_q.green_solid_ms  <= RST_GREEN_SOLID;
			cfg_q.blink_limit     <= RST_BLINK_LIMIT;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ON_THRESHOLD: cfg_q.on_threshold    <= cfg_wdata[LEVEL_W-1:0];
				REG_BOOT_HOLDOFF: cfg_q.boot_holdoff_ms <= cfg_wdata[MS_W-1:0];
				REG_RED_RECENT:   cfg_q.red_recent_ms   <= cfg_wdata[MS_W-1:0];
				REG_GREEN_SOLID:  cfg_q.green_solid_ms  <= cfg_wdata[MS_W-1:0];
				REG_BLINK_LIMIT:  cfg_q.blink_limit     <= cfg_wdata[BLINK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/lbec_core.sv */
// Classification logic and detection state of the LED blink error classifier.
`timescale 1ns / 1ps
module lbec_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  lbec_pkg::item_t  item,
	input  lbec_pkg::cfg_t   cfg,
	output lbec_pkg::result_t res
);
	import lbec_pkg::*;

	logic                boot_done_q;
	logic                green_prev_q;
	logic                red_prev_q;
	logic [TIME_W-1:0]   green_change_time_q;
	logic [TIME_W-1:0]   red_change_time_q;
	logic [BLINK_W-1:0]  green_blinks_q;
	logic                was_error_q;
	logic [2:0]          last_color_q;

	logic                boot_now;
	logic                g_on;
	logic                r_on;
	logic                g_chg;
	logic                r_chg;
	logic [TIME_W-1:0]   gct_nxt;
	logic [TIME_W-1:0]   rct_nxt;
	logic [TIME_W-1:0]   red_age;
	logic [TIME_W-1:0]   green_age;
	logic [BLINK_W-1:0]  blinks_inc;
	logic [BLINK_W-1:0]  blinks_nxt;
	logic                err;
	logic [1:0]          color;
	logic                write;

	// Threshold, edge timing and blink count
	always_comb begin
		boot_now   = boot_done_q | (item.now_ms > {{(TIME_W-MS_W){1'b0}}, cfg.boot_holdoff_ms});
		g_on       = item.green_level > cfg.on_threshold;
		r_on       = item.red_level > cfg.on_threshold;
		g_chg      = g_on != green_prev_q;
		r_chg      = r_on != red_prev_q;
		gct_nxt    = g_chg ? item.now_ms : green_change_time_q;
		rct_nxt    = r_chg ? item.now_ms : red_change_time_q;
		red_age    = item.now_ms - rct_nxt;
		green_age  = item.now_ms - gct_nxt;
		blinks_inc = (g_chg && g_on && green_blinks_q != BLINK_MAX)
			? green_blinks_q + 1'b1 : green_blinks_q;
		// error rule: once booted, any of these conditions flags an error
		err = boot_now & (r_on | ~g_on
			| (red_age < {{(TIME_W-MS_W){1'b0}}, cfg.red_recent_ms})
			| (blinks_inc > cfg.blink_limit));
		// steady green clears the count
		blinks_nxt = (g_on && green_age > {{(TIME_W-MS_W){1'b0}}, cfg.green_solid_ms})
			? '0 : blinks_inc;
		// orange, green, red, black map straight onto {green, red}
		color = {g_on, r_on};
		write = ~was_error_q | (last_color_q != {1'b0, color});
	end

	// Result word
	always_comb begin
		res.error_flag      = err;
		res.color_code      = err ? color : COLOR_BLACK;
		res.color_write     = err & write;
		res.rainbow_restart = ~err & was_error_q;
	end

	// Detection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_done_q         <= 1'b0;
			green_prev_q        <= 1'b0;
			red_prev_q          <= 1'b0;
			green_change_time_q <= '0;
			red_change_time_q   <= '0;
			green_blinks_q      <= '0;
			was_error_q         <= 1'b0;
			last_color_q        <= COLOR_NONE;
		end else if (fire) begin
			boot_done_q <= boot_now;
			was_error_q <= err;
			if (err) begin
				last_color_q <= {1'b0, color};
			end
			if (boot_now) begin
				green_prev_q        <= g_on;
				red_prev_q          <= r_on;
				green_change_time_q <= gct_nxt;
				red_change_time_q   <= rct_nxt;
				green_blinks_q      <= blinks_nxt;
			end
		end
	end

	// Boot flag is sticky
	a_boot_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(boot_done_q) |-> boot_done_q)
		else $error("boot flag cleared");

	// No error before boot
	a_no_err_pre_boot: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !boot_now) |-> !res.error_flag)
		else $error("error reported before boot");

	// Entering error mode always writes the colour
	a_enter_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && err && !was_error_q) |-> res.color_write)
		else $error("error entry without colour write");

	// A recorded colour only exists after an error
	a_last_color: assert property (@(posedge clk) disable iff (!arst_n)
		was_error_q |-> (last_color_q != COLOR_NONE))
		else $error("error mode without colour");

endmodule

/* sv/led_blink_error_classifier.sv */
// Top level of the LED blink error classifier: stream ports, input and result registers.
// Flow: a word accepted into the input register is classified and captured in the result
// register, which drives m_tdata; a low m_tready holds it there and stalls the input side.
// Throughput: one word per cycle while m_tready is high; the input and result registers
// form a two-stage pipeline and the detection state updates in the single logic stage.
// Reset: arst_n clears the pipeline, the detection state and loads register defaults.
`timescale 1ns / 1ps
module led_blink_error_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lbec_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [lbec_pkg::CFG_DW-1:0]   cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// green_level[9:0], red_level[19:10], now_ms[51:20], zero pad
	input  logic [lbec_pkg::IN_DW-1:0]    s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// error_flag[0], color_code[2:1], color_write[3], rainbow_restart[4], zero pad
	output logic [lbec_pkg::OUT_DW-1:0]   m_tdata
);
	import lbec_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    fire;

	lbec_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Stage 1 moves on when the result register is free or being drained
	assign advance  = ~valid_s2 | m_tready;
	assign fire     = valid_s1 & advance;
	assign s_tready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_tdata[$bits(item_t)-1:0];
		end
	end

	lbec_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_DW-$bits(result_t)){1'b0}}, res_s2};

endmodule
